// ===== design/qpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpc_pkg
// Shared types, constants and the step lookup for the quadrature position
// counter.
// ----------------------------------------------------------------------------
package qpc_pkg;

    localparam int COUNT_W = 8;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic signed [1:0]  step_t;
    typedef logic [1:0]         phase_t;

    localparam count_t PULSE_TOP_RESET = count_t'(32);

    localparam step_t STEP_NONE = 2'sb00;
    localparam step_t STEP_FWD  = 2'sb01;
    localparam step_t STEP_BWD  = 2'sb11;

    // Step for {previous phase, current phase}; phase = A + 2*B
    localparam step_t STEP_TABLE [0:15] = '{
        STEP_NONE, STEP_FWD,  STEP_BWD,  STEP_NONE,
        STEP_BWD,  STEP_NONE, STEP_NONE, STEP_FWD,
        STEP_FWD,  STEP_NONE, STEP_NONE, STEP_BWD,
        STEP_NONE, STEP_BWD,  STEP_FWD,  STEP_NONE
    };

    // Sample held in the input register, with its valid flag
    typedef struct packed {
        logic valid;
        logic channel_a;
        logic channel_b;
    } stage_t;

endpackage

// ===== design/qpc_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpc_sample_if
// Channel carrying one sample of the encoder channels A and B.
// ----------------------------------------------------------------------------
interface qpc_sample_if;

    logic valid;
    logic ready;
    logic channel_a;
    logic channel_b;

    modport source (output valid, output channel_a, output channel_b, input ready);
    modport sink   (input valid, input channel_a, input channel_b, output ready);

endinterface

// ===== design/qpc_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpc_result_if
// Channel carrying the position reported for each sample.
// ----------------------------------------------------------------------------
interface qpc_result_if
    import qpc_pkg::*;
();

    logic   valid;
    logic   ready;
    count_t pulse_count;
    count_t revolution_magnitude;
    logic   revolution_negative;
    step_t  step;

    modport source (
        output valid,
        output pulse_count,
        output revolution_magnitude,
        output revolution_negative,
        output step,
        input  ready
    );
    modport sink (
        input  valid,
        input  pulse_count,
        input  revolution_magnitude,
        input  revolution_negative,
        input  step,
        output ready
    );

endinterface

// ===== design/qpc_sample_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpc_sample_stage
// Input register: captures one sample per transfer and hands it downstream.
// ----------------------------------------------------------------------------
module qpc_sample_stage
    import qpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    qpc_sample_if.sink    sample,
    output stage_t        stage,
    input  logic          stage_ready
);

    logic valid_reg;
    logic valid_next;
    logic channel_a_reg;
    logic channel_b_reg;

    // Take a new sample whenever the register is empty or being drained
    assign sample.ready = !valid_reg || stage_ready;
    assign valid_next   = sample.ready ? sample.valid : valid_reg;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the sample levels on a transfer
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            channel_a_reg <= sample.channel_a;
            channel_b_reg <= sample.channel_b;
        end
    end

    assign stage.valid     = valid_reg;
    assign stage.channel_a = channel_a_reg;
    assign stage.channel_b = channel_b_reg;

endmodule

// ===== design/qpc_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpc_tracker
// Position state and result register: decodes the step from the previous
// and current phase, moves the pulse and revolution counts, and registers
// the result.
// ----------------------------------------------------------------------------
module qpc_tracker
    import qpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  stage_t        stage,
    output logic          stage_ready,
    input  count_t        pulse_top,
    qpc_result_if.source  result
);

    phase_t prev_phase_reg;
    count_t pulses_reg;
    count_t revs_reg;
    logic   negative_reg;

    count_t pulses_next;
    count_t revs_next;
    logic   negative_next;
    phase_t phase;
    step_t  step;

    logic   out_valid_reg;
    logic   out_valid_next;
    step_t  out_step_reg;
    logic   advance;

    // Move a sample into the result register when the output is free
    assign stage_ready = !out_valid_reg || result.ready;
    assign advance     = stage.valid && stage_ready;

    // Decode the step from the phase pair
    assign phase = {stage.channel_b, stage.channel_a};
    assign step  = STEP_TABLE[{prev_phase_reg, phase}];

    // Advance the pulse count and the sign-magnitude revolution count
    always_comb
    begin
        pulses_next   = pulses_reg;
        revs_next     = revs_reg;
        negative_next = negative_reg;
        case (step)
            STEP_FWD:
            begin
                if (pulses_reg == pulse_top)
                begin
                    pulses_next = '0;
                    if (!negative_reg)
                    begin
                        revs_next = revs_reg + count_t'(1);
                    end
                    else if (revs_reg == count_t'(1))
                    begin
                        negative_next = 1'b0;
                        revs_next     = '0;
                    end
                    else
                    begin
                        revs_next = revs_reg - count_t'(1);
                    end
                end
                else
                begin
                    pulses_next = pulses_reg + count_t'(1);
                end
            end
            STEP_BWD:
            begin
                if (pulses_reg == '0)
                begin
                    pulses_next = pulse_top;
                    if (negative_reg)
                    begin
                        revs_next = revs_reg + count_t'(1);
                    end
                    else if (revs_reg == '0)
                    begin
                        negative_next = 1'b1;
                        revs_next     = count_t'(1);
                    end
                    else
                    begin
                        revs_next = revs_reg - count_t'(1);
                    end
                end
                else
                begin
                    pulses_next = pulses_reg - count_t'(1);
                end
            end
            default:
            begin
                pulses_next = pulses_reg;
            end
        endcase
    end

    assign out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    // Hold position state and the result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_phase_reg <= '0;
            pulses_reg     <= '0;
            revs_reg       <= '0;
            negative_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                prev_phase_reg <= phase;
                pulses_reg     <= pulses_next;
                revs_reg       <= revs_next;
                negative_reg   <= negative_next;
            end
        end
    end

    // Register the step reported with the result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_step_reg <= step;
        end
    end

    // The state registers double as the result payload
    assign result.valid                = out_valid_reg;
    assign result.pulse_count          = pulses_reg;
    assign result.revolution_magnitude = revs_reg;
    assign result.revolution_negative  = negative_reg;
    assign result.step                 = out_step_reg;

endmodule

// ===== design/quadrature_position_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_position_counter
// Decodes sampled quadrature encoder levels into a pulse position and a
// sign-magnitude revolution count, one result per sample.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  sample    in         channel_a, channel_b
//  result    out        pulse_count, revolution_magnitude,
//                       revolution_negative, step
//  cfg       in         cfg_write_en, cfg_write_data (pulse_top)
//
//  One sample is taken per cycle while the result is not stalled; it passes
//  the input register, then the result register after the step logic.
//  Reset clears the position to +0 pulses, +0 revolutions, phase 0, and sets
//  pulse_top to 32.
//  A stalled result holds the result register; one more sample waits in the
//  input register, after which sample.ready drops.
// ----------------------------------------------------------------------------
module quadrature_position_counter
    import qpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    qpc_sample_if.sink    sample,
    qpc_result_if.source  result,
    input  logic          cfg_write_en,
    input  count_t        cfg_write_data
);

    count_t pulse_top_reg;
    stage_t stage;
    logic   stage_ready;

    // Hold the pulse top register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_top_reg <= PULSE_TOP_RESET;
        end
        else if (cfg_write_en)
        begin
            pulse_top_reg <= cfg_write_data;
        end
    end

    qpc_sample_stage u_sample_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .stage       (stage),
        .stage_ready (stage_ready)
    );

    qpc_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .stage_ready (stage_ready),
        .pulse_top   (pulse_top_reg),
        .result      (result)
    );

    // A sample leaving the input register always lands in the result register
    a_stage_to_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (stage.valid && stage_ready) |=> result.valid
    ) else $error("sample hand-off produced no result");

    // The step code for two's complement -2 is never produced
    a_step_legal: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.step != 2'sb10)
    ) else $error("illegal step code on result");

    // A still encoder leaves the position unchanged
    a_no_step_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (stage.valid && stage_ready && $past(stage.valid && stage_ready)
            && (result.step == STEP_NONE)) |->
            (result.pulse_count == $past(result.pulse_count))
    ) else $error("position moved without a step");

endmodule
